// ===== design/lbc_pkg.sv =====
// Shared types, constants and helpers for the line/box clipping block.
// No dependencies; every other file in design/ uses it by scoped names.
`default_nettype none

package lbc_pkg;

   // Field widths (Q16.16)
   localparam int CoordW = 32;
   localparam int ExtW   = 31;
   localparam int TolW   = 16;
   localparam int CsrDW  = 32;

   // Numerator d_b * (c - p_a): 32 x 33 bit signed
   localparam int NumW = 2 * CoordW + 1;

   // Divider: quotient bits 40..0, clamp magnitude is 2^40
   localparam int QuotBits  = 41;
   localparam int QW        = QuotBits + 1;
   localparam int DivStages = QuotBits + 2;

   // Faces in test order: z=0, y=0, x=0, z=Z, y=Y, x=X
   localparam int NumAxes  = 3;
   localparam int NumFaces = 6;
   localparam int NumDivs  = 2 * NumFaces;
   localparam int FaceAxis [NumFaces] = '{2, 1, 0, 2, 1, 0};
   localparam logic [NumFaces-1:0] FaceUpper = 6'b111000;

   typedef enum logic [1:0] {
      REG_X_EXTENT = 2'd0,
      REG_Y_EXTENT = 2'd1,
      REG_Z_EXTENT = 2'd2,
      REG_EDGE_TOL = 2'd3
   } csr_index_type;

   localparam logic [TolW-1:0] TolReset = 16'd66;

   typedef struct packed {
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] point_z;
      logic signed [CoordW-1:0] dir_x;
      logic signed [CoordW-1:0] dir_y;
      logic signed [CoordW-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic signed [CoordW-1:0] first_x;
      logic signed [CoordW-1:0] first_y;
      logic signed [CoordW-1:0] first_z;
      logic signed [CoordW-1:0] second_x;
      logic signed [CoordW-1:0] second_y;
      logic signed [CoordW-1:0] second_z;
   } rsp_type;

   // Point carried alongside the divider pipeline
   typedef struct packed {
      logic [NumAxes-1:0][CoordW-1:0] p;
      logic [NumFaces-1:0]            ok;
   } side_type;

   // The j-th (0 or 1) axis that is not axis a
   function automatic int other_axis(int a, int j);
      int b;
      b = a + 1 + j;
      if (b >= NumAxes) begin
         b = b - NumAxes;
      end
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== design/lbc_div.sv =====
// Pipelined signed divider with round-half-away and clamp to 2^40.
// One quotient bit per stage; depends on lbc_pkg.
`default_nettype none

module lbc_div (
   input  logic                                 clock,
   input  logic [lbc_pkg::DivStages-1:0]        adv,
   input  logic signed [lbc_pkg::NumW-1:0]      num,
   input  logic signed [lbc_pkg::CoordW-1:0]    den,
   output logic signed [lbc_pkg::QW-1:0]        quot
);

   localparam int NW = lbc_pkg::NumW;
   localparam int DW = lbc_pkg::CoordW + 1;
   localparam int QB = lbc_pkg::QuotBits;
   localparam int TW = DW + QB;

   // per-step state: stage 0 is the prepared operands
   logic [NW-1:0] rem_ff [QB+1];
   logic [DW-1:0] dsr_ff [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic          neg_ff [QB+1];
   logic          ovf_ff [QB+1];
   logic signed [lbc_pkg::QW-1:0] quot_ff;

   logic [NW-1:0]              an;
   logic [lbc_pkg::CoordW-1:0] ad;
   logic [NW-1:0]              n_in;
   logic [DW-1:0]              d2_in;
   logic                       ovf_in;

   logic [NW-1:0] rem_in [QB];
   logic [QB-1:0] q_in   [QB];
   logic [TW-1:0] shd;
   logic [TW-1:0] rem_w;

   logic [QB-1:0]                 mag;
   logic signed [lbc_pkg::QW-1:0] quot_in;

   // operand prep: N = 2|num| + |den|, D = 2|den|
   always_comb begin
      an     = num[NW-1] ? NW'(-num) : NW'(num);
      ad     = den[lbc_pkg::CoordW-1] ? lbc_pkg::CoordW'(-den) : lbc_pkg::CoordW'(den);
      n_in   = {an[NW-2:0], 1'b0} + NW'(ad);
      d2_in  = {ad, 1'b0};
      ovf_in = DW'(n_in[NW-1:QB]) >= d2_in;
   end

   // restoring steps, one quotient bit each
   always_comb begin
      for (int k = 0; k < QB; k++) begin
         shd   = TW'(dsr_ff[k]) << (QB - 1 - k);
         rem_w = TW'(rem_ff[k]);
         if (rem_w >= shd) begin
            rem_in[k] = NW'(rem_w - shd);
            q_in[k]   = q_ff[k] | (QB'(1) << (QB - 1 - k));
         end else begin
            rem_in[k] = rem_ff[k];
            q_in[k]   = q_ff[k];
         end
      end
   end

   // clamp and apply sign
   always_comb begin
      if (ovf_ff[QB] || (q_ff[QB] > (QB'(1) << (QB - 1)))) begin
         mag = QB'(1) << (QB - 1);
      end else begin
         mag = q_ff[QB];
      end
      quot_in = neg_ff[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_ff[0] <= n_in;
         dsr_ff[0] <= d2_in;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[NW-1] ^ den[lbc_pkg::CoordW-1];
         ovf_ff[0] <= ovf_in;
      end
      for (int k = 0; k < QB; k++) begin
         if (adv[k+1]) begin
            rem_ff[k+1] <= rem_in[k];
            dsr_ff[k+1] <= dsr_ff[k];
            q_ff[k+1]   <= q_in[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
      if (adv[QB+1]) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== design/line_box_clip_top.sv =====
// Top level of the line/box clipping block: config registers, face setup,
// twelve lbc_div dividers, hit test, dedup and result select. Uses lbc_pkg.
//
// Usage:
//  - req_* carries one line beat (point and direction, Q16.16). rsp_* returns
//    one beat per line: found plus the first two distinct face hits.
//  - csr_* writes x/y/z extent and edge tolerance; always ready. Write only
//    while no line is in flight.
//  - Fully pipelined: 49 register stages. One line enters per cycle when
//    nothing stalls; the depth is set by the 43-stage divider (41 one-bit
//    steps plus operand prep and output register).
//  - Each stage holds a valid bit and moves when the stage after it is empty
//    or moving, so bubbles are squeezed out and req_ready stays high while
//    any stage is free, even with a result waiting on rsp.
//  - When rsp_ready is low the result stays on rsp_data unchanged; nothing
//    is dropped or repeated.
//  - Reset clears all valid bits, extents to 0 and tolerance to 66.
`default_nettype none

module line_box_clip_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lbc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lbc_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  lbc_pkg::csr_index_type        csr_index,
   input  logic [lbc_pkg::CsrDW-1:0]     csr_data
);

   localparam int CW     = lbc_pkg::CoordW;
   localparam int NF     = lbc_pkg::NumFaces;
   localparam int NA     = lbc_pkg::NumAxes;
   localparam int HW     = lbc_pkg::QW + 1;
   localparam int SDiv0  = 3;
   localparam int SHit   = SDiv0 + lbc_pkg::DivStages;
   localparam int SEq    = SHit + 1;
   localparam int SOut   = SEq + 1;
   localparam int NStg   = SOut + 1;
   localparam logic signed [HW-1:0] SatHi = (HW'(1) << (CW - 1)) - HW'(1);
   localparam logic signed [HW-1:0] SatLo = -(HW'(1) << (CW - 1));

   // config registers
   logic [lbc_pkg::ExtW-1:0] ext_ff [NA];
   logic [lbc_pkg::TolW-1:0] tol_ff;

   // pipeline control
   logic [NStg-1:0] vld_ff;
   logic [NStg-1:0] adv;

   // stage 0: input beat
   lbc_pkg::req_type in_ff;
   logic signed [CW-1:0] p0 [NA];
   logic signed [CW-1:0] d0 [NA];
   logic [lbc_pkg::ExtW-1:0] c_val [NF];

   // stage 1: face plane offsets
   logic signed [CW:0]   diff_in [NF];
   logic signed [CW:0]   diff_ff [NF];
   logic signed [CW-1:0] p1_ff   [NA];
   logic signed [CW-1:0] d1_ff   [NA];

   // stage 2: numerators
   logic signed [lbc_pkg::NumW-1:0] num_in [lbc_pkg::NumDivs];
   logic signed [lbc_pkg::NumW-1:0] num_ff [lbc_pkg::NumDivs];
   logic signed [CW-1:0] p2_ff [NA];
   logic signed [CW-1:0] d2_ff [NA];
   logic [NF-1:0]        ok_in;
   logic [NF-1:0]        ok2_ff;
   int                   b_ax;

   // alongside the dividers
   lbc_pkg::side_type side_ff [lbc_pkg::DivStages];
   logic signed [lbc_pkg::QW-1:0] quot [lbc_pkg::NumDivs];

   // hit stage
   logic signed [HW-1:0] h;
   logic signed [HW-1:0] tol_s;
   logic signed [HW-1:0] ext_s;
   logic signed [HW-1:0] hsum;
   logic signed [HW-1:0] hdif;
   int                   a_ax;
   int                   qi;
   logic [NA-1:0][CW-1:0] hit_in [NF];
   logic [NF-1:0]         hok_in;
   logic [NA-1:0][CW-1:0] hit_ff [NF];
   logic [NF-1:0]         hok_ff;

   // equality stage
   logic [NF-1:0]         eq_in [NF];
   logic [NF-1:0]         eq_ff [NF];
   logic [NA-1:0][CW-1:0] hit2_ff [NF];
   logic [NF-1:0]         hok2_ff;

   // select stage
   logic [NF-1:0]         distinct;
   logic [1:0]            nsel;
   logic [NA-1:0][CW-1:0] first_pt;
   logic [NA-1:0][CW-1:0] second_pt;
   lbc_pkg::rsp_type      rsp_in;
   lbc_pkg::rsp_type      rsp_ff;

   // config write port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NA; k++) begin
            ext_ff[k] <= '0;
         end
         tol_ff <= lbc_pkg::TolReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            lbc_pkg::REG_X_EXTENT: ext_ff[0] <= csr_data[lbc_pkg::ExtW-1:0];
            lbc_pkg::REG_Y_EXTENT: ext_ff[1] <= csr_data[lbc_pkg::ExtW-1:0];
            lbc_pkg::REG_Z_EXTENT: ext_ff[2] <= csr_data[lbc_pkg::ExtW-1:0];
            lbc_pkg::REG_EDGE_TOL: tol_ff    <= csr_data[lbc_pkg::TolW-1:0];
            default: ;
         endcase
      end
   end

   // a stage may load when it or any stage after it has a hole,
   // or the result beat is being taken
   always_comb begin
      for (int s = 0; s < NStg; s++) begin
         adv[s] = rsp_ready || !(&(vld_ff | ((NStg'(1) << s) - NStg'(1))));
      end
   end

   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int s = 1; s < NStg; s++) begin
            if (adv[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   // stage 0: capture beat
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         in_ff <= req_data;
      end
   end

   // stage 1: c - p_a for each face
   always_comb begin
      p0[0] = in_ff.point_x;
      p0[1] = in_ff.point_y;
      p0[2] = in_ff.point_z;
      d0[0] = in_ff.dir_x;
      d0[1] = in_ff.dir_y;
      d0[2] = in_ff.dir_z;
      for (int f = 0; f < NF; f++) begin
         c_val[f]   = lbc_pkg::FaceUpper[f] ? ext_ff[lbc_pkg::FaceAxis[f]]
                                            : lbc_pkg::ExtW'(0);
         diff_in[f] = $signed({2'b00, c_val[f]})
                    - $signed({p0[lbc_pkg::FaceAxis[f]][CW-1], p0[lbc_pkg::FaceAxis[f]]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         diff_ff <= diff_in;
         p1_ff   <= p0;
         d1_ff   <= d0;
      end
   end

   // stage 2: d_b * (c - p_a) for both off-axis coordinates of every face
   always_comb begin
      b_ax = 0;
      for (int f = 0; f < NF; f++) begin
         ok_in[f] = d1_ff[lbc_pkg::FaceAxis[f]] != '0;
         for (int j = 0; j < 2; j++) begin
            b_ax = lbc_pkg::other_axis(lbc_pkg::FaceAxis[f], j);
            num_in[2*f+j] =
               $signed({{(lbc_pkg::NumW-CW){d1_ff[b_ax][CW-1]}}, d1_ff[b_ax]})
             * $signed({{(lbc_pkg::NumW-CW-1){diff_ff[f][CW]}}, diff_ff[f]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         num_ff <= num_in;
         p2_ff  <= p1_ff;
         d2_ff  <= d1_ff;
         ok2_ff <= ok_in;
      end
   end

   // dividers: numerator over d_a of the face
   for (genvar i = 0; i < lbc_pkg::NumDivs; i++) begin : g_div
      lbc_div u_div (
         .clock (clock),
         .adv   (adv[SDiv0 +: lbc_pkg::DivStages]),
         .num   (num_ff[i]),
         .den   (d2_ff[lbc_pkg::FaceAxis[i/2]]),
         .quot  (quot[i])
      );
   end

   // point and face-valid bits ride along with the dividers
   always_ff @(posedge clock) begin
      if (adv[SDiv0]) begin
         side_ff[0].p  <= {p2_ff[2], p2_ff[1], p2_ff[0]};
         side_ff[0].ok <= ok2_ff;
      end
      for (int k = 1; k < lbc_pkg::DivStages; k++) begin
         if (adv[SDiv0+k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // hit stage: build points, tolerance test, saturate
   always_comb begin
      tol_s = $signed({{(HW-lbc_pkg::TolW){1'b0}}, tol_ff});
      a_ax  = 0;
      qi    = 0;
      h     = '0;
      ext_s = '0;
      hsum  = '0;
      hdif  = '0;
      for (int f = 0; f < NF; f++) begin
         a_ax      = lbc_pkg::FaceAxis[f];
         hok_in[f] = side_ff[lbc_pkg::DivStages-1].ok[f];
         for (int k = 0; k < NA; k++) begin
            if (k == a_ax) begin
               h = $signed({{(HW-lbc_pkg::ExtW){1'b0}}, c_val[f]});
            end else begin
               qi = 2 * f + ((lbc_pkg::other_axis(a_ax, 0) == k) ? 0 : 1);
               h  = $signed({{(HW-CW){side_ff[lbc_pkg::DivStages-1].p[k][CW-1]}},
                             side_ff[lbc_pkg::DivStages-1].p[k]})
                  + $signed({quot[qi][lbc_pkg::QW-1], quot[qi]});
            end
            ext_s = $signed({{(HW-lbc_pkg::ExtW){1'b0}}, ext_ff[k]});
            hsum  = h + tol_s;
            hdif  = h - tol_s;
            if (hsum[HW-1] || (hdif > ext_s)) begin
               hok_in[f] = 1'b0;
            end
            if (h > SatHi) begin
               hit_in[f][k] = SatHi[CW-1:0];
            end else if (h < SatLo) begin
               hit_in[f][k] = SatLo[CW-1:0];
            end else begin
               hit_in[f][k] = h[CW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[SHit]) begin
         hit_ff <= hit_in;
         hok_ff <= hok_in;
      end
   end

   // equality stage: compare each hit against every earlier face
   always_comb begin
      for (int f = 0; f < NF; f++) begin
         for (int g = 0; g < NF; g++) begin
            eq_in[f][g] = (g < f) && (hit_ff[f] == hit_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[SEq]) begin
         eq_ff   <= eq_in;
         hit2_ff <= hit_ff;
         hok2_ff <= hok_ff;
      end
   end

   // select: a hit counts once, found when exactly two distinct points
   always_comb begin
      nsel      = '0;
      first_pt  = '0;
      second_pt = '0;
      for (int f = 0; f < NF; f++) begin
         distinct[f] = hok2_ff[f] && !(|(hok2_ff & eq_ff[f]));
         if (distinct[f]) begin
            if (nsel == 2'd0) begin
               first_pt = hit2_ff[f];
            end else if (nsel == 2'd1) begin
               second_pt = hit2_ff[f];
            end
            if (nsel != 2'd3) begin
               nsel = nsel + 2'd1;
            end
         end
      end
      rsp_in = '0;
      if ($countones(distinct) == 2) begin
         rsp_in.found    = 1'b1;
         rsp_in.first_x  = first_pt[0];
         rsp_in.first_y  = first_pt[1];
         rsp_in.first_z  = first_pt[2];
         rsp_in.second_x = second_pt[0];
         rsp_in.second_y = second_pt[1];
         rsp_in.second_z = second_pt[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[SOut]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[NStg-1];
   assign rsp_data  = rsp_ff;

   // checks
   a_zero_when_missed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.first_x == '0 && rsp_data.first_y == '0 && rsp_data.first_z == '0 &&
         rsp_data.second_x == '0 && rsp_data.second_y == '0 && rsp_data.second_z == '0)
      else $error("miss result carries nonzero points");

   a_hits_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |->
         rsp_data.first_x != rsp_data.second_x || rsp_data.first_y != rsp_data.second_y ||
         rsp_data.first_z != rsp_data.second_z)
      else $error("found result with two equal hits");

   a_beat_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted beat missing from first stage");

endmodule

`default_nettype wire

// ===== tb/sv/tb_line_box_clip_top.sv =====
// Self-checking testbench for line_box_clip_top: clips lines against the box
// and compares each result beat with a built-in predictor. Uses lbc_pkg.
`default_nettype none

module tb_line_box_clip_top;

   localparam int Latency = 49;
   localparam int WatchdogLimit = 20000;
   localparam int MaxErrPrint = 10;
   localparam int NumRandom = 1800;
   localparam longint One = 64'sd65536;
   localparam longint QLimit = 64'sd1 << 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   lbc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   lbc_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   lbc_pkg::csr_index_type csr_index = lbc_pkg::REG_X_EXTENT;
   logic [lbc_pkg::CsrDW-1:0] csr_data = '0;

   always #1 clock = ~clock;

   line_box_clip_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor copy of the registers
   longint box_ext [lbc_pkg::NumAxes];
   longint box_tol;

   lbc_pkg::rsp_type clip_queue[$];
   int err_count = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit rsp_side_done = 1'b0;

   // rounded quotient, ties away from zero, magnitude clamped to 2^40
   function automatic longint round_quot(longint num, longint den);
      bit neg;
      logic [127:0] an, ad, q;
      neg = (num < 0) != (den < 0);
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = (2 * an + ad) / (2 * ad);
      if (q > QLimit) q = QLimit;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic lbc_pkg::rsp_type clip_line(lbc_pkg::req_type r);
      longint p [lbc_pkg::NumAxes];
      longint d [lbc_pkg::NumAxes];
      longint h [lbc_pkg::NumAxes];
      longint kept [2][lbc_pkg::NumAxes];
      longint c;
      int hits, a;
      bit in_box, dup;
      lbc_pkg::rsp_type o;
      p[0] = longint'(r.point_x); p[1] = longint'(r.point_y); p[2] = longint'(r.point_z);
      d[0] = longint'(r.dir_x); d[1] = longint'(r.dir_y); d[2] = longint'(r.dir_z);
      hits = 0;
      o = '0;
      for (int f = 0; f < lbc_pkg::NumFaces; f++) begin
         a = lbc_pkg::FaceAxis[f];
         if (hits > 2 || d[a] == 0) continue;
         c = lbc_pkg::FaceUpper[f] ? box_ext[a] : 0;
         for (int k = 0; k < lbc_pkg::NumAxes; k++)
            h[k] = (k == a) ? c : p[k] + round_quot(d[k] * (c - p[a]), d[a]);
         in_box = 1'b1;
         for (int k = 0; k < lbc_pkg::NumAxes; k++)
            if (h[k] + box_tol < 0 || h[k] - box_tol > box_ext[k]) in_box = 1'b0;
         if (!in_box) continue;
         for (int k = 0; k < lbc_pkg::NumAxes; k++) h[k] = clamp32(h[k]);
         dup = 1'b0;
         for (int j = 0; j < hits && j < 2; j++)
            if (kept[j][0] == h[0] && kept[j][1] == h[1] && kept[j][2] == h[2])
               dup = 1'b1;
         if (dup) continue;
         if (hits < 2) kept[hits] = h;
         hits++;
      end
      if (hits == 2) begin
         o.found = 1'b1;
         o.first_x = kept[0][0][31:0];
         o.first_y = kept[0][1][31:0];
         o.first_z = kept[0][2][31:0];
         o.second_x = kept[1][0][31:0];
         o.second_y = kept[1][1][31:0];
         o.second_z = kept[1][2][31:0];
      end
      return o;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // csr_valid stays high between back-to-back writes; set_box drops it
   task automatic write_reg(lbc_pkg::csr_index_type idx, logic [lbc_pkg::CsrDW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lbc_pkg::REG_X_EXTENT: box_ext[0] = longint'(val[lbc_pkg::ExtW-1:0]);
         lbc_pkg::REG_Y_EXTENT: box_ext[1] = longint'(val[lbc_pkg::ExtW-1:0]);
         lbc_pkg::REG_Z_EXTENT: box_ext[2] = longint'(val[lbc_pkg::ExtW-1:0]);
         lbc_pkg::REG_EDGE_TOL: box_tol = longint'(val[lbc_pkg::TolW-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_box(logic [lbc_pkg::CsrDW-1:0] ex, logic [lbc_pkg::CsrDW-1:0] ey,
                          logic [lbc_pkg::CsrDW-1:0] ez, logic [lbc_pkg::CsrDW-1:0] tol);
      write_reg(lbc_pkg::REG_X_EXTENT, ex);
      write_reg(lbc_pkg::REG_Y_EXTENT, ey);
      write_reg(lbc_pkg::REG_Z_EXTENT, ez);
      write_reg(lbc_pkg::REG_EDGE_TOL, tol);
      csr_valid <= 1'b0;
   endtask

   // send one line; the expectation is queued at the accepting edge.
   // req_valid stays high after the beat until a gap or drain drops it.
   task automatic send_line(lbc_pkg::req_type r);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      clip_queue = {clip_queue, clip_line(r)};
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (clip_queue.size() != 0) @(posedge clock);
      repeat (Latency + 5) @(posedge clock);
   endtask

   function automatic longint rand_coord(longint span);
      case ($urandom_range(0, 4))
         0: return $signed($urandom());
         1: return longint'($urandom_range(0, 6)) * span / 4 - span / 4;
         default: return longint'($urandom_range(0, 32'hFFFF)) - 32768
                         + longint'($urandom_range(0, 4)) * span / 4;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_dir();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $signed($urandom());
         2: return $signed($urandom_range(0, 32)) - 16;
         default: return ($urandom_range(0, 1) ? -1 : 1) *
                         $signed($urandom_range(1, 4 * 65536));
      endcase
   endfunction

   // mostly lines aimed through the box, the rest raw noise
   function automatic lbc_pkg::req_type rand_line();
      lbc_pkg::req_type r;
      longint span;
      span = box_ext[0] + 1;
      if ($urandom_range(0, 7) == 0) begin
         r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         return r;
      end
      r.point_x = 32'(clamp32(rand_coord(box_ext[0] + 1)));
      r.point_y = 32'(clamp32(rand_coord(box_ext[1] + 1)));
      r.point_z = 32'(clamp32(rand_coord(box_ext[2] + 1)));
      r.dir_x = rand_dir();
      r.dir_y = rand_dir();
      r.dir_z = rand_dir();
      if (span < 0) r.dir_x = 0;
      return r;
   endfunction

   typedef struct {
      lbc_pkg::req_type line;
      bit               fixed_rsp;
      lbc_pkg::rsp_type rsp;
   } line_row_type;

   line_row_type dir_table[$];

   function automatic line_row_type row(lbc_pkg::req_type r, bit fx, lbc_pkg::rsp_type o);
      line_row_type t;
      t.line = r; t.fixed_rsp = fx; t.rsp = o;
      return t;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (clip_queue.size() == 0) begin
            err_count++;
            if (err_count <= MaxErrPrint) $display("unexpected beat %p", rsp_data);
         end else begin
            lbc_pkg::rsp_type want;
            want = clip_queue.pop_front();
            if (rsp_data !== want) begin
               err_count++;
               if (err_count <= MaxErrPrint)
                  $display("mismatch exp %p got %p", want, rsp_data);
            end
         end
      end
   end

   // receiver with random stalls and one long hold-off
   initial begin
      int g;
      while (!rsp_side_done) begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // watchdog on cycles with no accepted beat on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      lbc_pkg::req_type r;
      lbc_pkg::rsp_type none;
      longint big;
      none = '0;
      box_ext = '{0, 0, 0};
      box_tol = 66;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: zero box, a line through the origin along x meets one point
      r = '{0, 0, 0, One, 0, 0};
      send_line(r);
      drain();

      set_box(10 * One, 8 * One, 6 * One, 66);
      // axis lines, diagonal, zero direction, edges, extremes
      dir_table = {dir_table, row('{One, One, One, 0, 0, 0}, 1, none)};
      dir_table = {dir_table, row('{One, 2 * One, 3 * One, One, 0, 0}, 0, none)};
      dir_table = {dir_table, row('{One, 2 * One, 3 * One, 0, One, 0}, 0, none)};
      dir_table = {dir_table, row('{One, 2 * One, 3 * One, 0, 0, -One}, 0, none)};
      dir_table = {dir_table, row('{0, 0, 0, 5 * One, 4 * One, 3 * One}, 0, none)};
      dir_table = {dir_table, row('{0, 0, 0, One, One, One}, 0, none)};
      dir_table = {dir_table, row('{-5 * One, 3, 4, One, 0, 0}, 0, none)};
      dir_table = {dir_table, row('{50, -60, 3 * One, One, 0, 0}, 0, none)};
      dir_table = {dir_table, row('{One, -67, One, One, 0, 0}, 1, none)};
      dir_table = {dir_table, row('{One, 100 * One, One, One, 0, 0}, 1, none)};
      dir_table = {dir_table, row('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                                    32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000}, 0, none)};
      dir_table = {dir_table, row('{0, 0, 0, 32'sh7FFFFFFF, 1, -1}, 0, none)};
      dir_table = {dir_table, row('{One, One, 0, 1, 3, 32'sh80000000}, 0, none)};
      dir_table = {dir_table, row('{-1, -1, -1, 3, 7, 11}, 0, none)};
      dir_table = {dir_table, row('{32'sh80000000, 32'sh80000000, 32'sh80000000,
                                    -1, -1, -1}, 0, none)};
      foreach (dir_table[i]) begin
         send_line(dir_table[i].line);
         if (dir_table[i].fixed_rsp) clip_queue[$] = dir_table[i].rsp;
      end
      drain();

      // huge box, max tolerance: saturated hits
      big = 64'h7FFFFFFF;
      set_box(big, big, big, 16'hFFFF);
      send_line('{0, 0, 0, 1, 1, 1});
      send_line('{One, One, One, 32'sh7FFFFFFF, 2, 32'sh80000000});
      send_line('{32'sh80000000, 0, 0, 1, 32'sh7FFFFFFF, 0});
      drain();

      // random phases over several box settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_box(10 * One, 8 * One, 6 * One, 66);
            1: set_box($urandom(), $urandom(), $urandom(), $urandom());
            2: set_box(One, 2 * One, 3 * One, 0);
            3: set_box(0, 0, 0, 16'hFFFF);
            4: set_box($urandom_range(1, 512) * One, $urandom_range(1, 512) * One,
                       $urandom_range(1, 512) * One, $urandom_range(0, 200));
            default: set_box(32'hFFFFFFFF, 4 * One, 32'hFFFFFFFF, 66);
         endcase
         for (int n = 0; n < NumRandom / 6; n++) begin
            if (ph == 1 && n == 20) hold_rsp = 1'b1;
            if (ph == 2 && n == 100) begin
               req_valid <= 1'b0;
               while (clip_queue.size() != 0) @(posedge clock);
            end
            send_line(rand_line());
         end
         drain();
      end

      rsp_side_done = 1'b1;
      if (err_count == 0 && clip_queue.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
